// ----- hdl/sm3_pkg.sv -----
// sm3 hash engine package: round constants, iv, helper functions and shared types
// no dependencies
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int unsigned LEN_POS = 56;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] state8_t;

  localparam state8_t IV = {32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
                            32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F};

  // compression unit control from the sequencer
  typedef struct packed {
    logic start;
  } cmp_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_sts_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ----- hdl/sm3_compress.sv -----
// sm3 compression: one round per cycle over a 16-word sliding message window
// depends on sm3_pkg
module sm3_round_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  sm3_pkg::cmp_ctl_t ctl,
  input  sm3_pkg::word_t    blk [16],
  input  sm3_pkg::state8_t  cv_in,
  output sm3_pkg::state8_t  cv_out,
  output sm3_pkg::cmp_sts_t sts
);
  import sm3_pkg::*;

  word_t      w_r [16];
  word_t      w_nxt [16];
  state8_t    v_r, v_nxt;
  logic [5:0] rnd_r;
  logic       busy_r, done_r;

  word_t a12, ss1, ss2, ff, gg, tt1, tt2, tc, wnew;

  always_comb begin
    tc   = rotl((rnd_r < 6'd16) ? T_LOW : T_HIGH, rnd_r[4:0]);
    a12  = rotl(v_r[0], 5'd12);
    ss1  = rotl(a12 + v_r[4] + tc, 5'd7);
    ss2  = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = v_r[0] ^ v_r[1] ^ v_r[2];
      gg = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      ff = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gg = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    tt1  = ff + v_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2  = gg + v_r[7] + ss1 + w_r[0];
    // expansion word j+16 from window j..j+15
    wnew = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
    v_nxt = '{7: v_r[6], 6: rotl(v_r[5], 5'd19), 5: v_r[4], 4: perm0(tt2),
              3: v_r[2], 2: rotl(v_r[1], 5'd9), 1: v_r[0], 0: tt1};
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
    w_nxt[15] = wnew;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      w_r <= blk;
      v_r <= cv_in;
    end else if (busy_r) begin
      w_r <= w_nxt;
      v_r <= v_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) cv_out[i] = cv_in[i] ^ v_r[i];
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

`ifndef SYNTHESIS
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && rnd_r == 6'd63) |=> (done_r && !busy_r)) else $error("done missing");
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> rnd_r == 6'd0) else $error("round not cleared");
`endif

endmodule

// ----- hdl/sm3_hash_engine_core.sv -----
// sm3 hash engine top level: byte packer, padding sequencer and digest output
// depends on sm3_pkg and sm3_round_unit
// operation: a request is taken in idle, then its bytes are packed into the block one at
// a time; each full block goes to the round unit; a last request adds padding bytes, the
// length words and one or two blocks, then 8 digest words
// a new request is taken only once the last one is packed and any block it filled has
// been compressed by the round unit
// reset: synchronous active low; chaining value to iv, length and fill count to zero
module sm3_hash_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], byte_count[34:32], zero pad
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero pad
  output logic        out_tlast
);
  import sm3_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_BYTE = 7'b0000010, S_PAD = 7'b0000100,
    S_LEN  = 7'b0001000, S_CMP  = 7'b0010000, S_WAIT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t      st_r;
  word_t       blk_r [16];
  state8_t     cv_r, cv_new;
  logic [63:0] len_r;
  logic [5:0]  fill_r;
  logic [31:0] data_r;
  logic [2:0]  left_r, bidx_r;
  logic        last_r, pad_mark_r, len_blk_r;
  logic [2:0]  oidx_r;
  cmp_ctl_t    ctl;
  cmp_sts_t    sts;
  logic [7:0]  cur_byte;
  logic [2:0]  cnt;

  sm3_round_unit u_cmp (.clk(clk), .rst_n(rst_n), .ctl(ctl), .blk(blk_r), .cv_in(cv_r),
                        .cv_out(cv_new), .sts(sts));

  assign cnt       = (in_tdata[34:32] > 3'd4) ? 3'd4 : in_tdata[34:32];
  assign in_tready = (st_r == S_IDLE);
  assign ctl.start = (st_r == S_CMP);
  assign cur_byte  = (st_r == S_PAD) ? (pad_mark_r ? PAD_MARK : 8'h00)
                                     : data_r[8'd31 - {bidx_r, 3'b000} -: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cv_r    <= IV;
      len_r   <= '0;
      fill_r  <= '0;
      oidx_r  <= '0;
      left_r  <= '0;
      last_r  <= 1'b0;
      len_blk_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_tvalid) begin
          data_r <= in_tdata[31:0];
          left_r <= cnt;
          bidx_r <= '0;
          last_r <= in_tlast;
          len_r  <= len_r + {58'd0, cnt, 3'b000};
          pad_mark_r <= 1'b1;
          st_r   <= (cnt != 3'd0) ? S_BYTE : (in_tlast ? S_PAD : S_IDLE);
        end
        S_BYTE, S_PAD: begin
          blk_r[fill_r[5:2]][8'd31 - {fill_r[1:0], 3'b000} -: 8] <= cur_byte;
          fill_r <= fill_r + 6'd1;
          bidx_r <= bidx_r + 3'd1;
          // data bytes still owed only count down while packing the request
          if (st_r == S_PAD) pad_mark_r <= 1'b0;
          else left_r <= left_r - 3'd1;
          if (fill_r == 6'd63) begin
            len_blk_r <= 1'b0;
            st_r <= S_CMP;
          end else if (st_r == S_PAD) begin
            if (fill_r == 6'(LEN_POS - 1)) st_r <= S_LEN;
          end else if (left_r == 3'd1) begin
            st_r <= last_r ? S_PAD : S_IDLE;
          end
        end
        S_LEN: begin
          blk_r[14] <= len_r[63:32];
          blk_r[15] <= len_r[31:0];
          len_blk_r <= 1'b1;
          st_r <= S_CMP;
        end
        S_CMP: st_r <= S_WAIT;
        S_WAIT: if (sts.done) begin
          cv_r <= cv_new;
          if (len_blk_r) begin
            st_r <= S_OUT;
            oidx_r <= '0;
          end else if (left_r != 3'd0) begin
            st_r <= S_BYTE;
          end else if (last_r) begin
            st_r <= S_PAD;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_OUT: if (out_tready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            st_r   <= S_IDLE;
            cv_r   <= IV;
            len_r  <= '0;
            fill_r <= '0;
            len_blk_r <= 1'b0;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {5'd0, oidx_r, cv_r[oidx_r]};
  assign out_tlast  = (oidx_r == 3'd7);

`ifndef SYNTHESIS
  a_fill_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LEN) |-> fill_r == 6'(LEN_POS)) else $error("length at wrong offset");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(oidx_r)) else $error("output dropped");
  a_cmp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CMP) |-> !sts.busy) else $error("start while busy");
`endif

endmodule

// ----- tb/sv/sm3_digest_checker.sv -----
// sm3 digest checker: watches the message and digest streams, predicts digests
// depends on sm3_pkg for the iv and round constants
module sm3_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], byte_count[34:32], zero pad
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero pad
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          digests_seen
);
  import sm3_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_word;
  } digest_word_t;

  word_t        chain_q [8];
  word_t        block_q [16];
  logic [63:0]  msg_bits;
  int unsigned  fill_pos;
  digest_word_t digest_queue [$];

  function automatic word_t rol(word_t x, int unsigned n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  task automatic clear_state();
    for (int i = 0; i < 8; i++) chain_q[i] = IV[i];
    for (int i = 0; i < 16; i++) block_q[i] = '0;
    msg_bits = '0;
    fill_pos = 0;
  endtask

  task automatic compress_block();
    word_t w [68];
    word_t v [8];
    word_t a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = block_q[j];
    for (int j = 16; j < 68; j++) begin
      word_t x;
      x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
      w[j] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int j = 0; j < 64; j++) begin
      a12 = rol(v[0], 12);
      ss1 = rol(a12 + v[4] + rol(j < 16 ? T_LOW : T_HIGH, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
      v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4];
      v[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    for (int i = 0; i < 8; i++) chain_q[i] ^= v[i];
  endtask

  task automatic append_byte(logic [7:0] b);
    int unsigned sh;
    sh = (3 - (fill_pos % 4)) * 8;
    block_q[fill_pos / 4] = (block_q[fill_pos / 4] & ~(32'hFF << sh)) | (word_t'(b) << sh);
    fill_pos++;
    if (fill_pos == 64) begin
      compress_block();
      fill_pos = 0;
    end
  endtask

  task automatic absorb_request(logic [31:0] data, logic [2:0] count, logic fin);
    int unsigned n;
    n = (count > 4) ? 4 : count;
    for (int k = 0; k < n; k++) append_byte(data[31-8*k -: 8]);
    msg_bits += 64'(n * 8);
    if (fin) begin
      append_byte(PAD_MARK);
      while (fill_pos != LEN_POS) append_byte(8'h00);
      block_q[14] = msg_bits[63:32];
      block_q[15] = msg_bits[31:0];
      compress_block();
      for (int k = 0; k < 8; k++)
        digest_queue.push_back('{chain_q[k], 3'(k), k == 7});
      clear_state();
    end
  endtask

  initial clear_state();

  always @(posedge clk) begin
    digest_word_t got, exp_w;
    if (!rst_n) begin
      fail_count <= 0;
      digests_seen <= 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready)
        absorb_request(in_tdata[31:0], in_tdata[34:32], in_tlast);
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[31:0], out_tdata[34:32], out_tlast};
        if (digest_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected digest word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_queue.pop_front();
          if (got !== exp_w || out_tdata[39:35] !== 5'd0) begin
            if (fail_count < 10)
              $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       exp_w.word, exp_w.index, exp_w.last_word,
                       got.word, got.index, got.last_word);
            fail_count <= fail_count + 1;
          end
          if (got.last_word) digests_seen <= digests_seen + 1;
        end
      end
      pending <= digest_queue.size();
    end
  end
endmodule

// ----- tb/sv/sm3_hash_engine_core_test.sv -----
// sm3 hash engine testbench top: clock, reset, message stimulus and verdict
// depends on sm3_hash_engine_core and sm3_digest_checker
module sm3_hash_engine_core_test;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  int          fail_count, pending, digests_seen;
  int          send_idle = 0, recv_idle = 0;
  int          request_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sm3_hash_engine_core u_dut (.*);

  sm3_digest_checker u_check (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  // one request; holds valid until accepted, idles beforehand at random
  task automatic send_request(logic [31:0] data, logic [2:0] count, logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, count, data};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    request_count++;
  endtask

  // message of full words, then a last word of tail bytes
  task automatic send_message(int words, logic [2:0] tail);
    for (int i = 0; i < words; i++) send_request($urandom, 3'd4, 1'b0);
    send_request($urandom, tail, 1'b1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        // ragged stream: short words mid message and oversize counts
        for (int i = $urandom_range(20); i > 0; i--) begin
          send_request($urandom, 3'($urandom_range(7)), 1'b0);
          sent++;
        end
        send_request($urandom, 3'($urandom_range(7)), 1'b1);
      end else begin
        int w;
        w = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 18);
        send_message(w, 3'($urandom_range(4)));
        sent += w;
      end
      sent++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty, three bytes, block boundaries, all ones, oversize counts
    send_request(32'h0, 3'd0, 1'b1);
    send_request(32'h61626300, 3'd3, 1'b1);
    send_request(32'hFFFFFFFF, 3'd4, 1'b1);
    send_message(13, 3'd3);
    send_message(13, 3'd4);
    send_message(15, 3'd4);
    send_request(32'hFFFFFFFF, 3'd7, 1'b0);
    send_request(32'hA5A5A5A5, 3'd1, 1'b0);
    send_request(32'h00000000, 3'd5, 1'b0);
    send_request(32'h12345678, 3'd6, 1'b1);
    wait_drained();
    send_idle = 12; recv_idle = 76;
    random_phase(90);
    wait_drained();
    send_idle = 76; recv_idle = 12;
    random_phase(90);
    send_idle = 0; recv_idle = 0;
    random_phase(90);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("run: %0d message requests, %0d digests checked across idle mixes",
             request_count, digests_seen);
    if (fail_count == 0 && pending == 0)
      $display("** sm3_hash_engine_core: PASSED **");
    else
      $display("** sm3_hash_engine_core: FAILED **");
    $finish;
  end

  initial begin
    #5000000;
    $display("** sm3_hash_engine_core: FAILED **");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/sm3_pkg.sv
hdl/sm3_compress.sv
hdl/sm3_hash_engine_core.sv
tb/sv/sm3_digest_checker.sv
tb/sv/sm3_hash_engine_core_test.sv
